[rtl/srfp_pkg.sv]
package srfp_pkg;

   // Default payload position of the unit code inside a frame.
   localparam int DATA_OFFSET_DEFAULT = 9;

   // Entries in the queue between the byte classifier and the executor.
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] START_BYTE = 8'hAA;
   localparam logic [7:0] CMD_READ_A = 8'h60;
   localparam logic [7:0] CMD_READ_B = 8'h6F;

   // The address byte never comes earlier than this position.
   localparam logic [7:0] MIN_LAST_POS = 8'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_CSUM  = 2'd1;
   localparam logic [1:0] STATUS_SHORT = 2'd2;

   typedef enum logic [2:0] {
      OP_START,
      OP_LEN,
      OP_CMD,
      OP_BODY,
      OP_CHECK
   } op_type;

   // One classified byte, as handed from the front end to the executor.
   typedef struct packed {
      op_type      op;
      logic        data_en;
      logic [1:0]  slot;
      logic        addr_en;
      logic        too_short;
      logic [7:0]  value;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic [1:0]  frame_status;
      logic [7:0]  command_code;
      logic [7:0]  address_byte;
      logic [7:0]  unit_code;
      logic [15:0] reading;
      logic [7:0]  sensor_status;
   } result_type;

endpackage

[rtl/srfp_req_if.sv]
interface srfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

[rtl/srfp_rsp_if.sv]
interface srfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  frame_status;
   logic [7:0]  command_code;
   logic [7:0]  address_byte;
   logic [7:0]  unit_code;
   logic [15:0] reading;
   logic [7:0]  sensor_status;

   modport source (output valid, output frame_status, output command_code,
                   output address_byte, output unit_code, output reading,
                   output sensor_status, input ready);
   modport sink (input valid, input frame_status, input command_code,
                 input address_byte, input unit_code, input reading,
                 input sensor_status, output ready);
endinterface

[rtl/srfp_front.sv]
module srfp_front #(
   parameter int DATA_OFFSET = srfp_pkg::DATA_OFFSET_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   srfp_req_if.sink             req_ch,
   input  logic                 q_full,
   output logic                 push,
   output srfp_pkg::item_type   push_item
);
   import srfp_pkg::*;

   typedef enum logic [4:0] {
      PH_HUNT  = 5'b00001,
      PH_LEN   = 5'b00010,
      PH_CMD   = 5'b00100,
      PH_BODY  = 5'b01000,
      PH_CHECK = 5'b10000
   } phase_type;

   localparam logic [8:0] DATA_BEGIN = 9'(DATA_OFFSET);
   localparam logic [8:0] DATA_END   = 9'(DATA_OFFSET + 4);

   phase_type  phase_ff, phase_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] pos_ff, pos_in;
   logic [7:0] last_pos;
   logic [7:0] data_rel;
   logic       take;
   logic [7:0] b;

   assign req_ch.ready = !q_full;
   assign take         = req_ch.valid && req_ch.ready;
   assign b            = req_ch.rx_byte;
   assign last_pos     = (len_ff < MIN_LAST_POS) ? MIN_LAST_POS : len_ff;
   assign data_rel     = pos_ff - DATA_BEGIN[7:0];

   always_comb begin
      phase_in  = phase_ff;
      len_in    = len_ff;
      pos_in    = pos_ff;
      push      = 1'b0;
      push_item = '{op: OP_START, data_en: 1'b0, slot: data_rel[1:0], addr_en: 1'b0,
                    too_short: 1'b0, value: b};
      if (take) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (b == START_BYTE) begin
                  push     = 1'b1;
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               push         = 1'b1;
               push_item.op = OP_LEN;
               len_in       = b;
               phase_in     = PH_CMD;
            end
            PH_CMD: begin
               if (b == CMD_READ_A || b == CMD_READ_B) begin
                  push         = 1'b1;
                  push_item.op = OP_CMD;
                  pos_in       = MIN_LAST_POS;
                  phase_in     = PH_BODY;
               end else begin
                  // A bad command byte is swallowed; it never restarts a frame itself.
                  phase_in = PH_HUNT;
               end
            end
            PH_BODY: begin
               push              = 1'b1;
               push_item.op      = OP_BODY;
               push_item.data_en = ({1'b0, pos_ff} >= DATA_BEGIN) &&
                                   ({1'b0, pos_ff} < DATA_END);
               if (pos_ff >= last_pos) begin
                  push_item.addr_en = 1'b1;
                  phase_in          = PH_CHECK;
               end else begin
                  pos_in = pos_ff + 8'd1;
               end
            end
            PH_CHECK: begin
               push                = 1'b1;
               push_item.op        = OP_CHECK;
               push_item.too_short = {1'b0, len_ff} < DATA_END;
               phase_in            = PH_HUNT;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         len_ff   <= '0;
         pos_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

[rtl/srfp_queue.sv]
module srfp_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  srfp_pkg::item_type         push_item,
   input  logic                       pop,
   output srfp_pkg::item_type         head,
   output srfp_pkg::queue_status_type status
);
   import srfp_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   item_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[rtl/srfp_back.sv]
module srfp_back (
   input  logic                       clock,
   input  logic                       reset,
   input  srfp_pkg::item_type         head,
   input  srfp_pkg::queue_status_type q_status,
   output logic                       pop,
   srfp_rsp_if.source                 rsp_ch
);
   import srfp_pkg::*;

   logic [7:0] sum_ff, sum_in;
   logic [7:0] cmd_ff;
   logic [7:0] addr_ff;
   logic [7:0] data_ff [4];
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       check_pop;

   // A checksum byte may only leave the queue once the result register is free.
   assign pop       = !q_status.empty &&
                      (head.op != OP_CHECK || !out_valid_ff || rsp_ch.ready);
   assign check_pop = pop && (head.op == OP_CHECK);

   always_comb begin
      sum_in = sum_ff;
      if (pop) begin
         unique case (head.op)
            OP_START:                 sum_in = head.value;
            OP_LEN, OP_CMD, OP_BODY:  sum_in = sum_ff + head.value;
            OP_CHECK:                 sum_in = sum_ff;
            default:                  sum_in = sum_ff;
         endcase
      end
   end

   always_comb begin
      out_in.command_code = cmd_ff;
      out_in.address_byte = addr_ff;
      if (head.too_short) begin
         out_in.frame_status  = STATUS_SHORT;
         out_in.unit_code     = '0;
         out_in.reading       = '0;
         out_in.sensor_status = '0;
      end else begin
         out_in.frame_status  = (head.value == sum_ff) ? STATUS_OK : STATUS_CSUM;
         out_in.unit_code     = data_ff[0];
         out_in.reading       = {data_ff[2], data_ff[1]};
         out_in.sensor_status = data_ff[3];
      end
      out_valid_in = check_pop || (out_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      if (pop && head.op == OP_CMD) begin
         cmd_ff <= head.value;
      end
      if (pop && head.op == OP_BODY && head.data_en) begin
         data_ff[head.slot] <= head.value;
      end
      if (pop && head.op == OP_BODY && head.addr_en) begin
         addr_ff <= head.value;
      end
      if (check_pop) begin
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.frame_status  = out_ff.frame_status;
   assign rsp_ch.command_code  = out_ff.command_code;
   assign rsp_ch.address_byte  = out_ff.address_byte;
   assign rsp_ch.unit_code     = out_ff.unit_code;
   assign rsp_ch.reading       = out_ff.reading;
   assign rsp_ch.sensor_status = out_ff.sensor_status;

endmodule

[rtl/sensor_reply_frame_parser.sv]
// A result is registered in the output register after its checksum byte passes through the queue,
// provided the queue holds nothing older and the output register is free.
// Throughput: one byte request per cycle unless stalled; the front end drops or classifies
// each byte in the cycle it arrives, and the executor retires one queue entry per cycle.
// A result waiting in the output register holds back the next checksum byte; one more byte
// enters the queue behind it, and then the request channel stalls until the result leaves.
// Reset is synchronous and active high; it empties the queue and resumes start-byte hunting.
module sensor_reply_frame_parser #(
   parameter int DATA_OFFSET = srfp_pkg::DATA_OFFSET_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   srfp_req_if.sink   req_ch,
   srfp_rsp_if.source rsp_ch
);
   import srfp_pkg::*;

   // The front end tracks the frame layout: it knows where the length, command, payload,
   // address and checksum bytes fall and tags each byte accordingly. Bytes outside a frame
   // and a bad command byte never enter the queue.
   logic             push;
   item_type         push_item;
   item_type         head;
   queue_status_type q_status;
   logic             pop;

   srfp_front #(
      .DATA_OFFSET (DATA_OFFSET)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .q_full    (q_status.full),
      .push      (push),
      .push_item (push_item)
   );

   // The short queue lets the front end keep taking bytes while the executor waits for
   // the result register to drain.
   srfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   // The executor keeps the running checksum and the captured fields, and builds the
   // result when the checksum byte comes out of the queue.
   srfp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

`ifndef SYNTHESIS
   // The front end must never hand a byte to a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("byte pushed into a full queue");

   // A short frame reports no payload fields.
   a_short_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.frame_status == STATUS_SHORT) |->
         (rsp_ch.unit_code == '0 && rsp_ch.reading == '0 && rsp_ch.sensor_status == '0))
      else $error("short frame carries payload fields");

   // A result appears only after a checksum byte left the queue.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(pop && head.op == OP_CHECK))
      else $error("result without a checksum byte");
`endif

endmodule
